@@ src/nmrp_pkg.sv @@
// shared types and constants for the ndef message record parser
// no dependencies; imported by the step logic and the top level
package nmrp_pkg;

    localparam int unsigned MAX_RECORDS_RESET = 16;

    localparam int unsigned HDR_MB_BIT = 7;
    localparam int unsigned HDR_ME_BIT = 6;
    localparam int unsigned HDR_SR_BIT = 4;
    localparam int unsigned HDR_IL_BIT = 3;

    localparam logic [7:0] HDR_TNF_MASK   = 8'b0000_0111;
    localparam logic [7:0] RECORD_CNT_MAX = 8'hff;
    localparam logic [31:0] PAYLEN_SHORT  = 32'd1;
    localparam logic [31:0] PAYLEN_LONG   = 32'd4;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TYPELEN = 3'd1,
        PH_PAYLEN  = 3'd2,
        PH_IDLEN   = 3'd3,
        PH_TYPE    = 3'd4,
        PH_ID      = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_IDLE    = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_MANY  = 2'd1,
        ST_TRUNC = 2'd2
    } t_status;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] bytes_left;
        logic [7:0]  type_len;
        logic [7:0]  id_len;
        logic [31:0] payload_len;
        logic [7:0]  header;
        logic [7:0]  rec_cnt;
        t_status     status;
    } t_state;

    localparam t_state STATE_CLEAR = '{
        phase:       PH_HEADER,
        bytes_left:  32'd0,
        type_len:    8'd0,
        id_len:      8'd0,
        payload_len: 32'd0,
        header:      8'd0,
        rec_cnt:     8'd0,
        status:      ST_OK
    };

    typedef struct packed {
        logic [2:0]  field_kind;
        logic [7:0]  record_index;
        logic [2:0]  name_format;
        logic        short_record;
        logic        id_present;
        logic        begin_flag;
        logic        end_flag;
        logic [31:0] payload_size;
        logic        record_done;
        logic [1:0]  status;
    } t_result;

endpackage

@@ src/nmrp_in_if.sv @@
// input byte channel of the ndef message record parser
// no dependencies
interface nmrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_message;
    logic       end_of_message;

    modport source (output valid, output data_byte, output start_of_message,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input start_of_message,
                    input end_of_message, output ready);
endinterface

@@ src/nmrp_out_if.sv @@
// result channel of the ndef message record parser
// no dependencies
interface nmrp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  field_kind;
    logic [7:0]  record_index;
    logic [2:0]  name_format;
    logic        short_record;
    logic        id_present;
    logic        begin_flag;
    logic        end_flag;
    logic [31:0] payload_size;
    logic        record_done;
    logic [1:0]  status;

    modport source (output valid, output field_kind, output record_index,
                    output name_format, output short_record, output id_present,
                    output begin_flag, output end_flag, output payload_size,
                    output record_done, output status, input ready);
    modport sink   (input valid, input field_kind, input record_index,
                    input name_format, input short_record, input id_present,
                    input begin_flag, input end_flag, input payload_size,
                    input record_done, input status, output ready);
endinterface

@@ src/nmrp_cfg_if.sv @@
// configuration write channel carrying max_records
// no dependencies
interface nmrp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/ndef_message_record_parser_unit.sv @@
// top level of the ndef message record parser: input register, step logic, result register
// depends on nmrp_pkg, nmrp_in_if, nmrp_out_if, nmrp_cfg_if and nmrp_step
//
// Labels each byte of an NDEF message with the record field it belongs to and
// reports the header flags, decoded payload length, record index, end of record
// and a sticky status. One byte is taken every clock cycle in steady state while the
// output is not stalled; a byte's result goes via the input register, then the result
// register, and the single per-byte parser state update between them sets that rate.
// Either side may stall at any time; max_records must be written through the
// configuration channel while no bytes are in flight; the block does not enforce this.
module ndef_message_record_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nmrp_in_if.sink     i_in,
    nmrp_out_if.source  o_out,
    nmrp_cfg_if.sink    i_cfg
);
    import nmrp_pkg::*;

    logic       r_s1_valid;
    logic [7:0] r_s1_data;
    logic       r_s1_som;
    logic       r_s1_eom;
    logic       r_out_valid;
    t_result    r_out;
    t_state     r_state;
    logic [7:0] r_max_records;

    t_state     n_state;
    t_result    n_out;
    logic       adv;

    assign adv        = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || adv;
    assign i_cfg.ready = 1'b1;

    nmrp_step u_step (
        .i_state       (r_state),
        .i_max_records (r_max_records),
        .i_data_byte   (r_s1_data),
        .i_som         (r_s1_som),
        .i_eom         (r_s1_eom),
        .o_state       (n_state),
        .o_result      (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state       <= STATE_CLEAR;
            r_max_records <= 8'(MAX_RECORDS_RESET);
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_max_records <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_data <= i_in.data_byte;
            r_s1_som  <= i_in.start_of_message;
            r_s1_eom  <= i_in.end_of_message;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.field_kind   = r_out.field_kind;
    assign o_out.record_index = r_out.record_index;
    assign o_out.name_format  = r_out.name_format;
    assign o_out.short_record = r_out.short_record;
    assign o_out.id_present   = r_out.id_present;
    assign o_out.begin_flag   = r_out.begin_flag;
    assign o_out.end_flag     = r_out.end_flag;
    assign o_out.payload_size = r_out.payload_size;
    assign o_out.record_done  = r_out.record_done;
    assign o_out.status       = r_out.status;

endmodule

@@ src/nmrp_step.sv @@
// one parser step: next parser state and result for one message byte
// depends on nmrp_pkg
module nmrp_step (
    input  nmrp_pkg::t_state  i_state,
    input  logic [7:0]        i_max_records,
    input  logic [7:0]        i_data_byte,
    input  logic              i_som,
    input  logic              i_eom,
    output nmrp_pkg::t_state  o_state,
    output nmrp_pkg::t_result o_result
);
    import nmrp_pkg::*;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] left;
        logic        done;
    } t_entry;

    // first nonempty body field at or after kind k
    function automatic t_entry enter_body(
        input t_phase      k,
        input logic [7:0]  tl,
        input logic [7:0]  idl,
        input logic [7:0]  hdr,
        input logic [31:0] pl
    );
        t_entry e;
        e = '{phase: PH_HEADER, left: 32'd0, done: 1'b1};
        if (k <= PH_TYPE && tl != 8'd0) begin
            e = '{phase: PH_TYPE, left: {24'd0, tl}, done: 1'b0};
        end else if (k <= PH_ID && hdr[HDR_IL_BIT] && idl != 8'd0) begin
            e = '{phase: PH_ID, left: {24'd0, idl}, done: 1'b0};
        end else if (k <= PH_PAYLOAD && pl != 32'd0) begin
            e = '{phase: PH_PAYLOAD, left: pl, done: 1'b0};
        end
        return e;
    endfunction

    t_state cur;
    t_state nxt;
    t_entry ent;
    logic   done;
    logic   last;

    always_comb begin
        cur  = i_som ? STATE_CLEAR : i_state;
        nxt  = cur;
        done = 1'b0;
        ent  = '{phase: PH_HEADER, left: 32'd0, done: 1'b0};
        last = cur.bytes_left <= 32'd1;
        case (cur.phase)
            PH_HEADER: begin
                if (cur.rec_cnt >= i_max_records && cur.status == ST_OK) begin
                    nxt.status = ST_MANY;
                end
                nxt.header      = i_data_byte;
                nxt.type_len    = 8'd0;
                nxt.id_len      = 8'd0;
                nxt.payload_len = 32'd0;
                nxt.phase       = PH_TYPELEN;
                nxt.bytes_left  = 32'd0;
            end
            PH_TYPELEN: begin
                nxt.type_len = i_data_byte;
                nxt.phase    = PH_PAYLEN;
                if (cur.header[HDR_SR_BIT] || (cur.header & HDR_TNF_MASK) == 8'd0) begin
                    nxt.bytes_left = PAYLEN_SHORT;
                end else begin
                    nxt.bytes_left = PAYLEN_LONG;
                end
            end
            PH_PAYLEN: begin
                nxt.payload_len = {cur.payload_len[23:0], i_data_byte};
                if (last) begin
                    if (cur.header[HDR_IL_BIT]) begin
                        nxt.phase      = PH_IDLEN;
                        nxt.bytes_left = 32'd0;
                    end else begin
                        ent = enter_body(PH_TYPE, cur.type_len, cur.id_len, cur.header,
                                         nxt.payload_len);
                        nxt.phase      = ent.phase;
                        nxt.bytes_left = ent.left;
                        done           = ent.done;
                    end
                end else begin
                    nxt.bytes_left = cur.bytes_left - 32'd1;
                end
            end
            PH_IDLEN: begin
                nxt.id_len     = i_data_byte;
                ent            = enter_body(PH_TYPE, cur.type_len, i_data_byte, cur.header,
                                            cur.payload_len);
                nxt.phase      = ent.phase;
                nxt.bytes_left = ent.left;
                done           = ent.done;
            end
            PH_TYPE, PH_ID, PH_PAYLOAD: begin
                if (last) begin
                    ent = enter_body(t_phase'(3'(cur.phase) + 3'd1), cur.type_len,
                                     cur.id_len, cur.header, cur.payload_len);
                    nxt.phase      = ent.phase;
                    nxt.bytes_left = ent.left;
                    done           = ent.done;
                end else begin
                    nxt.bytes_left = cur.bytes_left - 32'd1;
                end
            end
            default: begin
            end
        endcase

        if (done && cur.rec_cnt != RECORD_CNT_MAX) begin
            nxt.rec_cnt = cur.rec_cnt + 8'd1;
        end

        if (i_eom && cur.phase != PH_IDLE) begin
            if (!done && nxt.status == ST_OK) begin
                nxt.status = ST_TRUNC;
            end
            nxt.phase      = PH_IDLE;
            nxt.bytes_left = 32'd0;
        end
    end

    assign o_state = nxt;

    always_comb begin
        o_result.field_kind   = cur.phase;
        o_result.record_index = cur.rec_cnt;
        o_result.name_format  = nxt.header[2:0];
        o_result.short_record = nxt.header[HDR_SR_BIT];
        o_result.id_present   = nxt.header[HDR_IL_BIT];
        o_result.begin_flag   = nxt.header[HDR_MB_BIT];
        o_result.end_flag     = nxt.header[HDR_ME_BIT];
        o_result.payload_size = nxt.payload_len;
        o_result.record_done  = done;
        o_result.status       = nxt.status;
    end

endmodule
